[hdl/rrf_pkg.sv]
// Shared constants, types and pointer helpers for the record ring FIFO.
package rrf_pkg;

	// Ring geometry
	localparam int DEPTH     = 64;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int DEPTH_W   = PTR_W + 1;
	localparam int BATCH_MAX = 8;
	localparam int CNT_W     = 4;
	localparam int PEEK_LIM  = (BATCH_MAX < 8) ? BATCH_MAX : 8;
	localparam int REC_W     = 32;

	// Field widths
	localparam int CMD_W     = 3;
	localparam int HALF_W    = 16;
	localparam int REL_W     = 7;
	localparam int OCC_W     = 6;

	// Packed word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ENQ  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLR  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;        // run a single-word operation and load its result
		logic peek_start;  // latch peek length and read the head record
		logic peek_emit;   // load the current peek record and read the next
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic peek_last;
	} stat_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_PEEK = 2'b10
	} state_t;

	// Advance a pointer by one, wrapping at the ring size in use
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr,
		input logic [DEPTH_W-1:0] depth);
		logic [DEPTH_W-1:0] inc;
		inc = {1'b0, ptr} + DEPTH_W'(1);
		return (inc >= depth) ? '0 : inc[PTR_W-1:0];
	endfunction

	// Entries held between head and tail
	function automatic logic [PTR_W-1:0] held_cnt(input logic [PTR_W-1:0] head,
		input logic [PTR_W-1:0] tail, input logic [DEPTH_W-1:0] depth);
		logic [DEPTH_W-1:0] s;
		if (tail >= head) begin
			s = {1'b0, tail} - {1'b0, head};
		end else begin
			s = {1'b0, tail} + depth - {1'b0, head};
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

[hdl/rrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/rrf_dp.sv]
// Datapath: pointers, ring size, record store, peek counters and result register.
module rrf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rrf_pkg::DEPTH_W-1:0]       cfg_wdata,
	input  logic [rrf_pkg::CMD_W-1:0]         cmd,
	input  logic [rrf_pkg::HALF_W-1:0]        entry_id,
	input  logic [rrf_pkg::HALF_W-1:0]        entry_seq,
	input  logic [rrf_pkg::REL_W-1:0]         release_count,
	input  rrf_pkg::ctl_t                     ctl,
	output rrf_pkg::stat_t                    stat,
	output logic                              ok,
	output logic [rrf_pkg::HALF_W-1:0]        out_id,
	output logic [rrf_pkg::HALF_W-1:0]        out_seq,
	output logic                              last,
	output logic [rrf_pkg::CNT_W-1:0]         emitted_count,
	output logic [rrf_pkg::OCC_W-1:0]         occupancy,
	output logic [rrf_pkg::OCC_W-1:0]         tail_position
);

	localparam int PW = rrf_pkg::PTR_W;
	localparam int DW = rrf_pkg::DEPTH_W;
	localparam int CW = rrf_pkg::CNT_W;

	logic [DW-1:0] depth_q;
	logic [PW-1:0] head_q, tail_q, pk_ptr_q;
	logic [CW-1:0] pk_cnt_q, pk_idx_q;

	logic [PW-1:0] held, held_nx, head_nx, tail_nx, tail_inc, rel_head;
	logic          full, empty, op_ok, rel_fail;
	logic [DW-1:0] rel_take, rel_sum, depth_cfg;
	logic [CW-1:0] pk_cnt, pk_idx_inc;
	logic          ram_we, ram_re;
	logic [PW-1:0] ram_raddr;
	logic [rrf_pkg::REC_W-1:0] ram_rdata;

	// Occupancy and full/empty flags
	assign held     = rrf_pkg::held_cnt(head_q, tail_q, depth_q);
	assign tail_inc = rrf_pkg::next_ptr(tail_q, depth_q);
	assign full     = (tail_inc == head_q);
	assign empty    = (head_q == tail_q);

	// Release: remove up to the held count, fail when more was asked
	assign rel_fail = ({1'b0, release_count} > {2'b0, held});
	assign rel_take = rel_fail ? {1'b0, held} : DW'(release_count);
	assign rel_sum  = {1'b0, head_q} + rel_take;
	assign rel_head = (rel_sum >= depth_q) ? PW'(rel_sum - depth_q) : rel_sum[PW-1:0];

	// Peek length and progress
	assign pk_cnt     = (held < PW'(rrf_pkg::PEEK_LIM)) ? CW'(held) : CW'(rrf_pkg::PEEK_LIM);
	assign pk_idx_inc = pk_idx_q + CW'(1);

	assign stat.empty     = empty;
	assign stat.peek_last = (pk_idx_inc == pk_cnt_q);

	// Clamp the written ring size
	always_comb begin
		depth_cfg = cfg_wdata;
		if (cfg_wdata < DW'(2)) begin
			depth_cfg = DW'(2);
		end else if (cfg_wdata > DW'(rrf_pkg::DEPTH)) begin
			depth_cfg = DW'(rrf_pkg::DEPTH);
		end
	end

	// Next pointers for single-word operations
	always_comb begin
		head_nx = head_q;
		tail_nx = tail_q;
		op_ok   = 1'b0;
		unique case (cmd)
			rrf_pkg::CMD_ENQ: begin
				if (!full) begin
					tail_nx = tail_inc;
					op_ok   = 1'b1;
				end
			end
			rrf_pkg::CMD_DEQ: begin
				if (!empty) begin
					head_nx = rrf_pkg::next_ptr(head_q, depth_q);
					op_ok   = 1'b1;
				end
			end
			rrf_pkg::CMD_CLR: begin
				head_nx = '0;
				tail_nx = '0;
				op_ok   = 1'b1;
			end
			rrf_pkg::CMD_REL: begin
				head_nx = rel_head;
				op_ok   = !rel_fail;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign held_nx = rrf_pkg::held_cnt(head_nx, tail_nx, depth_q);

	// Record store
	assign ram_we    = ctl.exec && (cmd == rrf_pkg::CMD_ENQ) && !full;
	assign ram_re    = ctl.peek_start || ctl.peek_emit;
	assign ram_raddr = ctl.peek_start ? head_q : rrf_pkg::next_ptr(pk_ptr_q, depth_q);

	rrf_ram #(
		.WIDTH(rrf_pkg::REC_W),
		.DEPTH(rrf_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata ({entry_id, entry_seq}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Ring size and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DW'(rrf_pkg::DEPTH);
			head_q  <= '0;
			tail_q  <= '0;
		end else if (cfg_we) begin
			depth_q <= depth_cfg;
			head_q  <= '0;
			tail_q  <= '0;
		end else if (ctl.exec) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
		end
	end

	// Peek walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_ptr_q <= '0;
			pk_cnt_q <= '0;
			pk_idx_q <= '0;
		end else if (ctl.peek_start) begin
			pk_ptr_q <= head_q;
			pk_cnt_q <= pk_cnt;
			pk_idx_q <= '0;
		end else if (ctl.peek_emit) begin
			pk_ptr_q <= rrf_pkg::next_ptr(pk_ptr_q, depth_q);
			pk_idx_q <= pk_idx_inc;
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			ok            <= op_ok;
			out_id        <= '0;
			out_seq       <= '0;
			last          <= 1'b1;
			emitted_count <= '0;
			occupancy     <= held_nx;
			tail_position <= tail_nx;
		end else if (ctl.peek_emit) begin
			ok            <= 1'b1;
			out_id        <= ram_rdata[rrf_pkg::REC_W-1:rrf_pkg::HALF_W];
			out_seq       <= ram_rdata[rrf_pkg::HALF_W-1:0];
			last          <= stat.peek_last;
			emitted_count <= pk_idx_inc;
			occupancy     <= held;
			tail_position <= tail_q;
		end
	end

`ifndef SYNTHESIS
	a_head_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < depth_q) else $error("head pointer beyond ring size");
	a_tail_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q < depth_q) else $error("tail pointer beyond ring size");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.peek_emit |-> (pk_idx_q < pk_cnt_q))
		else $error("peek emitted past its length");
	a_peek_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.peek_start |=> (pk_cnt_q != '0) && (pk_idx_q == '0))
		else $error("peek started on an empty ring");
`endif

endmodule

[hdl/rrf_ctrl.sv]
// Controller: input acceptance, peek sequencing and output word valid.
module rrf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rrf_pkg::CMD_W-1:0]     cmd,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  rrf_pkg::stat_t                stat,
	output rrf_pkg::ctl_t                 ctl
);

	rrf_pkg::state_t state_q, state_d;
	logic            out_free, accept, load;

	// Output register can take a word this cycle
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == rrf_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Issue commands and pick the next state
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			rrf_pkg::ST_IDLE: begin
				if (accept) begin
					if ((cmd == rrf_pkg::CMD_PEEK) && !stat.empty) begin
						ctl.peek_start = 1'b1;
						state_d        = rrf_pkg::ST_PEEK;
					end else begin
						ctl.exec = 1'b1;
					end
				end
			end
			rrf_pkg::ST_PEEK: begin
				if (out_free) begin
					ctl.peek_emit = 1'b1;
					if (stat.peek_last) begin
						state_d = rrf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rrf_pkg::ST_IDLE;
			end
		endcase
	end

	assign load = ctl.exec || ctl.peek_emit;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rrf_pkg::ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

[hdl/record_ring_fifo_with_batch_peek.sv]
// Top level of the record ring FIFO with batch peek.
// Circular FIFO of (id, seq) records with one slot always kept empty, so it holds at most
// depth_in_use-1 records (ring size 2..64, reset 64; a write clamps to that range and empties
// the ring). Commands on s_tdata: enqueue, dequeue, clear, release n and batch peek; each
// returns one result word with ok, occupancy and tail after the operation, except a peek of a
// non-empty ring, which returns min(held, 8) record words from the head without removing
// them, the final one marked by m_tlast. Enqueue, dequeue, clear, release, an empty peek and
// an unknown command are accepted back to back while the output register drains. A peek
// keeps the input closed until its last record word is loaded: the accepting cycle starts
// the registered read of the head record, then one record word leaves per cycle while the
// output is not stalled. The store needs no clearing pass after reset; only written entries
// between head and tail are read.
module record_ring_fifo_with_batch_peek (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rrf_pkg::DEPTH_W-1:0]         cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cmd[2:0], entry_id[18:3], entry_seq[34:19], release_count[41:35], zero pad
	input  logic [rrf_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// ok[0], out_id[16:1], out_seq[32:17], emitted_count[36:33],
	// occupancy[42:37], tail_position[48:43], zero pad
	output logic [rrf_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast
);

	rrf_pkg::ctl_t  ctl;
	rrf_pkg::stat_t stat;

	logic                         ok;
	logic [rrf_pkg::HALF_W-1:0]   out_id, out_seq;
	logic [rrf_pkg::CNT_W-1:0]    emitted_count;
	logic [rrf_pkg::OCC_W-1:0]    occupancy, tail_position;

	// Unpack the input word
	logic [rrf_pkg::CMD_W-1:0]    cmd;
	logic [rrf_pkg::HALF_W-1:0]   entry_id, entry_seq;
	logic [rrf_pkg::REL_W-1:0]    release_count;

	assign cmd           = s_tdata[2:0];
	assign entry_id      = s_tdata[18:3];
	assign entry_seq     = s_tdata[34:19];
	assign release_count = s_tdata[41:35];

	rrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	rrf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.entry_id      (entry_id),
		.entry_seq     (entry_seq),
		.release_count (release_count),
		.ctl           (ctl),
		.stat          (stat),
		.ok            (ok),
		.out_id        (out_id),
		.out_seq       (out_seq),
		.last          (m_tlast),
		.emitted_count (emitted_count),
		.occupancy     (occupancy),
		.tail_position (tail_position)
	);

	// Pack the output word
	assign m_tdata = {7'b0, tail_position, occupancy, emitted_count, out_seq, out_id, ok};

endmodule

[tb/sv/ring_check_pkg.sv]
// Command and result word types plus the scoreboard for the record ring FIFO bench.
package ring_check_pkg;

	import rrf_pkg::*;

	// Command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// Command word, packed so that cmd sits in the lowest bits as on s_tdata
	typedef struct packed {
		logic [REL_W-1:0]  rel;
		logic [HALF_W-1:0] seq;
		logic [HALF_W-1:0] id;
		logic [CMD_W-1:0]  cmd;
	} ring_cmd_t;

	// Result word as seen on the master side, tlast included
	typedef struct packed {
		logic              ok;
		logic [HALF_W-1:0] id;
		logic [HALF_W-1:0] seq;
		logic              last;
		logic [CNT_W-1:0]  count;
		logic [OCC_W-1:0]  occ;
		logic [PTR_W-1:0]  tail;
	} ring_result_t;

	class ring_scoreboard;
		logic [REC_W-1:0] records [DEPTH];
		int               head;
		int               tail;
		int               depth;
		ring_result_t     due_results [$];
		int               fault_count;
		int               words_noted;
		int               results_seen;

		function new();
			head = 0;
			tail = 0;
			depth = DEPTH;
			fault_count = 0;
			words_noted = 0;
			results_seen = 0;
		endfunction

		// Step a ring index by one, wrapping at the size in use
		function int advance(input int p);
			return (p + 1 >= depth) ? 0 : p + 1;
		endfunction

		function int held();
			return (tail >= head) ? tail - head : tail + depth - head;
		endfunction

		// A size write clamps to the legal range and empties the ring
		function void set_depth(input int v);
			depth = (v < 2) ? 2 : (v > DEPTH) ? DEPTH : v;
			head = 0;
			tail = 0;
		endfunction

		// Apply one accepted command word and queue the result words it causes
		function void note_word(input ring_cmd_t w);
			ring_result_t r;
			ring_result_t e;
			int n;
			int p;
			words_noted++;
			r = '0;
			r.last = 1'b1;
			n = 0;
			case (w.cmd)
				CMD_ENQ: begin
					if (advance(tail) != head) begin
						records[tail] = {w.id, w.seq};
						tail = advance(tail);
						r.ok = 1'b1;
					end
				end
				CMD_DEQ: begin
					if (head != tail) begin
						head = advance(head);
						r.ok = 1'b1;
					end
				end
				CMD_CLR: begin
					head = 0;
					tail = 0;
					r.ok = 1'b1;
				end
				CMD_REL: begin
					// drop entries one at a time; running dry fails but keeps what went
					n = w.rel;
					while (n > 0 && head != tail) begin
						head = advance(head);
						n = n - 1;
					end
					r.ok = (n == 0);
					n = 0;
				end
				CMD_PEEK: begin
					n = held();
					if (n > PEEK_LIM) begin
						n = PEEK_LIM;
					end
					p = head;
					for (int i = 0; i < n; i++) begin
						e = '0;
						e.ok = 1'b1;
						e.id = records[p][REC_W-1:HALF_W];
						e.seq = records[p][HALF_W-1:0];
						e.last = (i == n - 1);
						e.count = CNT_W'(i + 1);
						e.occ = OCC_W'(held());
						e.tail = PTR_W'(tail);
						due_results.push_back(e);
						p = advance(p);
					end
				end
				default: ;
			endcase
			// everything but a non-empty peek gives a single status word
			if (n == 0) begin
				r.occ = OCC_W'(held());
				r.tail = PTR_W'(tail);
				due_results.push_back(r);
			end
		endfunction

		function void log_fault(input string what, input ring_result_t want,
			input ring_result_t got);
			fault_count++;
			if (fault_count <= 10) begin
				$display("%s: want ok=%0d id=%h seq=%h last=%0d cnt=%0d occ=%0d tail=%0d",
					what, want.ok, want.id, want.seq, want.last, want.count, want.occ,
					want.tail);
				$display("    got ok=%0d id=%h seq=%h last=%0d cnt=%0d occ=%0d tail=%0d",
					got.ok, got.id, got.seq, got.last, got.count, got.occ, got.tail);
			end
		endfunction

		// Compare one result word with the oldest one due
		function void check_result(input ring_result_t got);
			ring_result_t want;
			results_seen++;
			if (due_results.size() == 0) begin
				log_fault("result word with nothing due", '0, got);
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				log_fault("result word mismatch", want, got);
			end
		endfunction
	endclass

endpackage

[tb/sv/tb_record_ring_fifo_with_batch_peek.sv]
// Self-checking bench for the record ring FIFO: directed and random command streams.
module tb_record_ring_fifo_with_batch_peek;

	import rrf_pkg::*;
	import ring_check_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REL_MAX       = (1 << REL_W) - 1;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [DEPTH_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	ring_scoreboard sb;
	ring_result_t   seen_word;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             cycle_count = 0;
	int             depths_used = 1;

	record_ring_fifo_with_batch_peek dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stall the result side at the rate of the current phase
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check every result word taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_word.ok = m_tdata[0];
			seen_word.id = m_tdata[16:1];
			seen_word.seq = m_tdata[32:17];
			seen_word.count = m_tdata[36:33];
			seen_word.occ = m_tdata[42:37];
			seen_word.tail = m_tdata[48:43];
			seen_word.last = m_tlast;
			sb.check_result(seen_word);
		end
	end

	// Offer one command word, holding it until taken; call and return at a falling edge
	task automatic send_word(input ring_cmd_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = IN_TDATA_W'(w);
		do @(posedge clk); while (!s_tready);
		sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HALF_W-1:0] id,
		input logic [HALF_W-1:0] seq, input logic [REL_W-1:0] rel);
		ring_cmd_t w;
		w.cmd = cmd;
		w.id = id;
		w.seq = seq;
		w.rel = rel;
		send_word(w);
	endtask

	// Write the ring size once the block has gone quiet
	task automatic write_depth(input logic [DEPTH_W-1:0] v);
		s_tvalid = 1'b0;
		while (sb.due_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_depth(v);
		depths_used++;
	endtask

	// Random command word, enqueue-leaning so the ring fills and wraps
	function automatic ring_cmd_t rand_word(input int enq_pct);
		ring_cmd_t w;
		int pick;
		w.id = HALF_W'($urandom);
		w.seq = HALF_W'($urandom);
		w.rel = REL_W'($urandom_range(0, sb.depth));
		if ($urandom_range(0, 7) == 0) begin
			w.rel = REL_W'($urandom_range(0, REL_MAX));
		end
		pick = $urandom_range(0, 99);
		if (pick < enq_pct) begin
			w.cmd = CMD_ENQ;
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 6) begin
				w.cmd = CMD_DEQ;
			end else if (pick < 12) begin
				w.cmd = CMD_PEEK;
			end else if (pick < 17) begin
				w.cmd = CMD_REL;
			end else if (pick < 18) begin
				w.cmd = CMD_CLR;
			end else begin
				w.cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			end
		end
		return w;
	endfunction

	task automatic run_random(input int count, input int enq_pct);
		repeat (count) send_word(rand_word(enq_pct));
	endtask

	initial begin
		sb = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Empty ring at full size: underflow, empty peek, release of zero and of one
		send_cmd(CMD_DEQ, '0, '0, '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		send_cmd(CMD_REL, '0, '0, 7'd0);
		send_cmd(CMD_REL, '0, '0, 7'd1);
		// Fill exactly one batch, with extreme field values at the head
		send_cmd(CMD_ENQ, 16'hFFFF, 16'h0000, '0);
		send_cmd(CMD_ENQ, 16'h0000, 16'hFFFF, '0);
		repeat (6) send_cmd(CMD_ENQ, HALF_W'($urandom), HALF_W'($urandom), '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		send_cmd(CMD_REL, '0, '0, 7'd3);
		send_cmd(CMD_DEQ, '0, '0, '0);
		send_cmd(CMD_SPARE_LO, 16'hFFFF, 16'hFFFF, 7'h7F);
		send_cmd(CMD_SPARE_LO + 3'd1, '0, '0, '0);
		send_cmd(CMD_SPARE_HI, '0, '0, '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		// Release more than held, then clear
		send_cmd(CMD_REL, '0, '0, 7'h7F);
		send_cmd(CMD_CLR, '0, '0, '0);

		// Smallest ring via a write below range: overflow and wrap
		write_depth('0);
		send_cmd(CMD_ENQ, 16'h1234, 16'h5678, '0);
		send_cmd(CMD_ENQ, 16'h9ABC, 16'hDEF0, '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		send_cmd(CMD_DEQ, '0, '0, '0);
		send_cmd(CMD_ENQ, 16'hA5A5, 16'h5A5A, '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		send_cmd(CMD_REL, '0, '0, 7'd2);

		// Full size via a write above range: fill to overflow, no idling
		write_depth({DEPTH_W{1'b1}});
		repeat (DEPTH + 2) send_cmd(CMD_ENQ, HALF_W'($urandom), HALF_W'($urandom), '0);
		send_cmd(CMD_PEEK, '0, '0, '0);
		send_cmd(CMD_REL, '0, '0, 7'(DEPTH));
		run_random(15, 30);

		// Sender mostly idle on a tiny ring
		send_idle_pct = 81;
		write_depth(7'd3);
		run_random(60, 50);

		// Receiver mostly stalled at full size, enqueue-heavy
		send_idle_pct = 0;
		recv_stall_pct = 81;
		write_depth(7'(DEPTH));
		run_random(50, 60);

		// Both sides idling lightly on a mid-sized ring
		send_idle_pct = 24;
		recv_stall_pct = 24;
		write_depth(7'($urandom_range(4, 16)));
		run_random(60, 50);

		// Two-slot ring, no idling
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_depth(7'd2);
		run_random(40, 50);

		// Any size the register takes
		send_idle_pct = 24;
		recv_stall_pct = 24;
		write_depth(7'($urandom_range(0, REL_MAX)));
		run_random(60, 45);

		// Drain and let any stray word show up
		s_tvalid = 1'b0;
		recv_stall_pct = 0;
		while (sb.due_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d command words and checked %0d result words over %0d ring sizes,",
			sb.words_noted, sb.results_seen, depths_used);
		$display("with no, sender, receiver and two-sided idling; %0d faults found.",
			sb.fault_count);
		if (sb.fault_count == 0 && sb.due_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[record_ring_fifo_with_batch_peek.f]
hdl/rrf_pkg.sv
hdl/rrf_ram.sv
hdl/rrf_dp.sv
hdl/rrf_ctrl.sv
hdl/record_ring_fifo_with_batch_peek.sv
tb/sv/ring_check_pkg.sv
tb/sv/tb_record_ring_fifo_with_batch_peek.sv
